// ===== rtl/core/qsarl_pkg.sv =====
// qsarl_pkg: widths, action codes and handshake structs for the queue state
// address reverse lookup block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package qsarl_pkg;

   // field widths of one request and one response beat
   localparam int ACTION_W    = 2;
   localparam int IFC_W       = 11;
   localparam int TYPE_W      = 3;
   localparam int PAGE_W      = 22;
   localparam int CNT_CODE_W  = 4;
   localparam int SIZE_CODE_W = 3;
   localparam int ADDR_W      = 29;
   localparam int QID_W       = 15;

   // a 4 KiB page is 2^(12-5) units of 32 bytes
   localparam int PAGE_SHIFT  = 12 - 5;

   // geometry word: count code low, size code high
   localparam int GEOM_W      = CNT_CODE_W + SIZE_CODE_W;
   // shift amount count + size, at most 22
   localparam int SHIFT_W     = 5;
   // sum of up to 8 spans of at most 2^22 units
   localparam int OFF_W       = 22 + $clog2(8) + 1;

   localparam int REQ_FIELDS_W = IFC_W + TYPE_W + 1 + PAGE_W + CNT_CODE_W
                                 + SIZE_CODE_W + ADDR_W;
   localparam int REQ_TDATA_W  = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = IFC_W + TYPE_W + QID_W;
   localparam int RSP_TDATA_W  = ((RSP_FIELDS_W + 7) / 8) * 8;

   localparam int NUM_INTERFACES_DEF = 2048;
   localparam int NUM_TYPES_DEF      = 8;

   localparam logic [ACTION_W-1:0] ACT_WR_HDR  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_WR_GEOM = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_LOOKUP  = 2'd2;

   typedef struct packed {
      logic             valid;
      logic             last;
      logic [IFC_W-1:0] idx;
   } match_req_type;

   typedef struct packed {
      logic              valid;
      logic              last;
      logic              hit;
      logic [IFC_W-1:0]  idx;
      logic [TYPE_W-1:0] qtype;
      logic [QID_W-1:0]  qid;
   } match_rsp_type;

endpackage

`default_nettype wire

// ===== rtl/core/qsarl_ram.sv =====
// qsarl_ram: generic simple dual-port ram, one write and one registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module qsarl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/qsarl_match.sv =====
// qsarl_match: three-stage match unit, tests one table entry per cycle
// against the lookup address; depends on qsarl_pkg
`timescale 1ns / 1ps
`default_nettype none

module qsarl_match #(
   parameter int NUM_TYPES = qsarl_pkg::NUM_TYPES_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          flush,
   input  wire qsarl_pkg::match_req_type      mreq,
   input  wire logic                          entry_valid,
   input  wire logic [qsarl_pkg::PAGE_W-1:0]  base_page,
   input  wire logic [NUM_TYPES-1:0][qsarl_pkg::GEOM_W-1:0] geom,
   input  wire logic [qsarl_pkg::ADDR_W-1:0]  lookup_addr,
   output qsarl_pkg::match_rsp_type           mrsp
);

   localparam int ADDR_W  = qsarl_pkg::ADDR_W;
   localparam int OFF_W   = qsarl_pkg::OFF_W;
   localparam int CW      = qsarl_pkg::CNT_CODE_W;
   localparam int SW      = qsarl_pkg::SIZE_CODE_W;
   localparam int GW      = qsarl_pkg::GEOM_W;
   localparam int SHIFT_W = qsarl_pkg::SHIFT_W;

   // stage 1: offset from base and running type boundaries
   logic                                s1_valid_ff;
   logic                                s1_last_ff;
   logic [qsarl_pkg::IFC_W-1:0]         s1_idx_ff;
   logic                                s1_possible_ff;
   logic [ADDR_W-1:0]                   s1_rel_ff;
   logic [NUM_TYPES-1:0][OFF_W-1:0]     s1_start_ff;
   logic [NUM_TYPES-1:0][OFF_W-1:0]     s1_end_ff;
   logic [NUM_TYPES-1:0][SW-1:0]        s1_sz_ff;

   logic [ADDR_W:0]                     diff_in;
   logic [NUM_TYPES-1:0][OFF_W-1:0]     start_in;
   logic [NUM_TYPES-1:0][OFF_W-1:0]     end_in;
   logic [NUM_TYPES-1:0][SW-1:0]        sz_in;

   always_comb begin
      logic [OFF_W-1:0]   acc;
      logic [SHIFT_W-1:0] sh;
      diff_in = {1'b0, lookup_addr}
                - {1'b0, base_page, {qsarl_pkg::PAGE_SHIFT{1'b0}}};
      acc = '0;
      for (int t = 0; t < NUM_TYPES; t++) begin
         sz_in[t]    = geom[t][GW-1:CW];
         sh          = SHIFT_W'(geom[t][CW-1:0]) + SHIFT_W'(geom[t][GW-1:CW]);
         start_in[t] = acc;
         acc         = acc + (OFF_W'(1) << sh);
         end_in[t]   = acc;
      end
   end

   // stage 2: first type whose end lies above the offset
   logic                                s2_valid_ff;
   logic                                s2_last_ff;
   logic [qsarl_pkg::IFC_W-1:0]         s2_idx_ff;
   logic                                s2_hit_ff;
   logic [qsarl_pkg::TYPE_W-1:0]        s2_type_ff;
   logic [OFF_W-1:0]                    s2_off_ff;
   logic [SW-1:0]                       s2_sz_ff;
   logic [ADDR_W-1:0]                   s2_rel_ff;

   logic                                hit_in;
   logic [qsarl_pkg::TYPE_W-1:0]        type_in;
   logic [OFF_W-1:0]                    off_in;
   logic [SW-1:0]                       sel_sz_in;

   always_comb begin
      logic any;
      any       = 1'b0;
      type_in   = '0;
      off_in    = '0;
      sel_sz_in = '0;
      // walk down so the lowest matching type wins
      for (int t = NUM_TYPES - 1; t >= 0; t--) begin
         if (s1_rel_ff < ADDR_W'(s1_end_ff[t])) begin
            any       = 1'b1;
            type_in   = qsarl_pkg::TYPE_W'(t);
            off_in    = s1_start_ff[t];
            sel_sz_in = s1_sz_ff[t];
         end
      end
      hit_in = s1_possible_ff && any;
   end

   // stage 3: queue index is the offset within the type over the queue size
   logic [ADDR_W-1:0]            delta_in;
   logic [qsarl_pkg::QID_W-1:0]  qid_in;
   qsarl_pkg::match_rsp_type     mrsp_ff;

   always_comb begin
      delta_in = s2_rel_ff - ADDR_W'(s2_off_ff);
      qid_in   = qsarl_pkg::QID_W'(delta_in >> s2_sz_ff);
   end

   always_ff @(posedge clock) begin
      if (reset || flush) begin
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         mrsp_ff.valid <= 1'b0;
      end else begin
         s1_valid_ff   <= mreq.valid;
         s2_valid_ff   <= s1_valid_ff;
         mrsp_ff.valid <= s2_valid_ff;
      end
      s1_last_ff     <= mreq.last;
      s1_idx_ff      <= mreq.idx;
      s1_possible_ff <= entry_valid && !diff_in[ADDR_W];
      s1_rel_ff      <= diff_in[ADDR_W-1:0];
      s1_start_ff    <= start_in;
      s1_end_ff      <= end_in;
      s1_sz_ff       <= sz_in;

      s2_last_ff <= s1_last_ff;
      s2_idx_ff  <= s1_idx_ff;
      s2_hit_ff  <= hit_in;
      s2_type_ff <= type_in;
      s2_off_ff  <= off_in;
      s2_sz_ff   <= sel_sz_in;
      s2_rel_ff  <= s1_rel_ff;

      mrsp_ff.last  <= s2_last_ff;
      mrsp_ff.hit   <= s2_hit_ff;
      mrsp_ff.idx   <= s2_idx_ff;
      mrsp_ff.qtype <= s2_type_ff;
      mrsp_ff.qid   <= qid_in;
   end

   assign mrsp = mrsp_ff;

endmodule

`default_nettype wire

// ===== rtl/core/queue_state_address_reverse_lookup_top.sv =====
// queue_state_address_reverse_lookup_top: interface table, scan sequencer
// and result register; depends on qsarl_pkg, qsarl_ram and qsarl_match
//
// usage:
//   req channel carries one command per beat, kind in req_tuser: write an
//   interface header (valid bit, base page), write one type's geometry
//   (count and size codes), or look up a 32-byte-granular address.
//   rsp channel returns one beat per lookup: found in rsp_tuser, interface,
//   type and queue index in rsp_tdata (all zero when nothing matches).
//   writes give no beat.
//   a lookup walks the table one entry per cycle through the match unit:
//   a hit on entry i goes through the table read register, the match
//   stages and the rsp register; a miss is answered once the last entry has
//   left the match unit. the scan length set by the single table read port
//   is the rate limit; one lookup at a time.
//   after reset the block sweeps the table clearing every valid bit, one
//   entry per cycle, req_tready low. a waiting response sits in an output
//   register; while rsp is stalled no new command is taken.
`timescale 1ns / 1ps
`default_nettype none

module queue_state_address_reverse_lookup_top #(
   parameter int NUM_INTERFACES = qsarl_pkg::NUM_INTERFACES_DEF,
   parameter int NUM_TYPES      = qsarl_pkg::NUM_TYPES_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // interface_index, type_index, entry_valid, base_page, count_code,
   // size_code, lookup_addr, zero fill
   input  wire logic [qsarl_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // action
   input  wire logic [qsarl_pkg::ACTION_W-1:0]     req_tuser,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // interface_id, queue_type, queue_id, zero fill
   output logic      [qsarl_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   // found
   output logic                                    rsp_tuser
);

   localparam int IFC_W  = qsarl_pkg::IFC_W;
   localparam int TYPE_W = qsarl_pkg::TYPE_W;
   localparam int PAGE_W = qsarl_pkg::PAGE_W;
   localparam int CW     = qsarl_pkg::CNT_CODE_W;
   localparam int SW     = qsarl_pkg::SIZE_CODE_W;
   localparam int GW     = qsarl_pkg::GEOM_W;
   localparam int ADDR_W = qsarl_pkg::ADDR_W;
   localparam int QID_W  = qsarl_pkg::QID_W;
   localparam int AW     = (NUM_INTERFACES > 1) ? $clog2(NUM_INTERFACES) : 1;
   localparam int CNT_W  = $clog2(NUM_INTERFACES + 1);

   localparam int TIX_LO  = IFC_W;
   localparam int VLD_LO  = TIX_LO + TYPE_W;
   localparam int PAGE_LO = VLD_LO + 1;
   localparam int CNT_LO  = PAGE_LO + PAGE_W;
   localparam int SZ_LO   = CNT_LO + CW;
   localparam int ADDR_LO = SZ_LO + SW;
   localparam int RSP_PAD = qsarl_pkg::RSP_TDATA_W - qsarl_pkg::RSP_FIELDS_W;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP
   } state_type;

   // request fields
   logic [IFC_W-1:0]  req_ifc;
   logic [TYPE_W-1:0] req_tix;
   logic              req_vld;
   logic [PAGE_W-1:0] req_page;
   logic [CW-1:0]     req_cnt;
   logic [SW-1:0]     req_sz;
   logic [ADDR_W-1:0] req_addr;

   assign req_ifc  = req_tdata[TIX_LO-1:0];
   assign req_tix  = req_tdata[VLD_LO-1:TIX_LO];
   assign req_vld  = req_tdata[VLD_LO];
   assign req_page = req_tdata[CNT_LO-1:PAGE_LO];
   assign req_cnt  = req_tdata[SZ_LO-1:CNT_LO];
   assign req_sz   = req_tdata[ADDR_LO-1:SZ_LO];
   assign req_addr = req_tdata[ADDR_LO+ADDR_W-1:ADDR_LO];

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   issue_ff, issue_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_found_ff, rsp_found_in;
   logic [IFC_W-1:0]   rsp_ifc_ff, rsp_ifc_in;
   logic [TYPE_W-1:0]  rsp_type_ff, rsp_type_in;
   logic [QID_W-1:0]   rsp_qid_ff, rsp_qid_in;
   logic               rd_vld_ff;
   logic               rd_last_ff;
   logic [IFC_W-1:0]   rd_idx_ff;

   logic accept;
   logic ifc_ok;
   logic tix_ok;
   logic flush;
   logic rd_en;
   logic issue_more;

   qsarl_pkg::match_req_type mreq;
   qsarl_pkg::match_rsp_type mrsp;

   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign ifc_ok     = {21'd0, req_ifc} < 32'(NUM_INTERFACES);
   assign tix_ok     = {29'd0, req_tix} < 32'(NUM_TYPES);
   assign issue_more = issue_ff < CNT_W'(NUM_INTERFACES);

   // entry table: valid bit on top of the base page
   logic              ent_we;
   logic [AW-1:0]     ent_waddr;
   logic [PAGE_W:0]   ent_wdata;
   logic [PAGE_W:0]   ent_rd;

   assign ent_we    = (state_ff == ST_CLEAR)
                      || (accept && req_tuser == qsarl_pkg::ACT_WR_HDR && ifc_ok);
   assign ent_waddr = (state_ff == ST_CLEAR) ? issue_ff[AW-1:0] : AW'(req_ifc);
   assign ent_wdata = (state_ff == ST_CLEAR) ? '0 : {req_vld, req_page};

   assign rd_en = (state_ff == ST_LOOKUP) && issue_more && !flush;

   qsarl_ram #(
      .WIDTH (PAGE_W + 1),
      .DEPTH (NUM_INTERFACES),
      .AW    (AW)
   ) u_ent_ram (
      .clock   (clock),
      .wr_en   (ent_we),
      .wr_addr (ent_waddr),
      .wr_data (ent_wdata),
      .rd_en   (rd_en),
      .rd_addr (issue_ff[AW-1:0]),
      .rd_data (ent_rd)
   );

   // one geometry ram per type so an entry's types read out together
   logic [NUM_TYPES-1:0][GW-1:0] geom_rd;

   for (genvar t = 0; t < NUM_TYPES; t++) begin : g_geom
      logic geom_we;
      logic [GW-1:0] geom_rdata;

      assign geom_we = accept && req_tuser == qsarl_pkg::ACT_WR_GEOM && ifc_ok
                       && tix_ok && req_tix == TYPE_W'(t);

      qsarl_ram #(
         .WIDTH (GW),
         .DEPTH (NUM_INTERFACES),
         .AW    (AW)
      ) u_geom_ram (
         .clock   (clock),
         .wr_en   (geom_we),
         .wr_addr (AW'(req_ifc)),
         .wr_data ({req_sz, req_cnt}),
         .rd_en   (rd_en),
         .rd_addr (issue_ff[AW-1:0]),
         .rd_data (geom_rdata)
      );

      assign geom_rd[t] = geom_rdata;
   end

   assign mreq.valid = rd_vld_ff;
   assign mreq.last  = rd_last_ff;
   assign mreq.idx   = rd_idx_ff;

   qsarl_match #(
      .NUM_TYPES (NUM_TYPES)
   ) u_match (
      .clock       (clock),
      .reset       (reset),
      .flush       (flush),
      .mreq        (mreq),
      .entry_valid (ent_rd[PAGE_W]),
      .base_page   (ent_rd[PAGE_W-1:0]),
      .geom        (geom_rd),
      .lookup_addr (addr_ff),
      .mrsp        (mrsp)
   );

   always_comb begin
      state_in     = state_ff;
      issue_in     = issue_ff;
      addr_in      = addr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_found_in = rsp_found_ff;
      rsp_ifc_in   = rsp_ifc_ff;
      rsp_type_in  = rsp_type_ff;
      rsp_qid_in   = rsp_qid_ff;
      flush        = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            issue_in = issue_ff + CNT_W'(1);
            if (issue_ff == CNT_W'(NUM_INTERFACES - 1)) begin
               state_in = ST_IDLE;
               issue_in = '0;
            end
         end
         ST_IDLE: begin
            if (accept && req_tuser == qsarl_pkg::ACT_LOOKUP) begin
               state_in = ST_LOOKUP;
               issue_in = '0;
               addr_in  = req_addr;
            end
         end
         ST_LOOKUP: begin
            if (issue_more) begin
               issue_in = issue_ff + CNT_W'(1);
            end
            // first hit in table order, or the last entry missed
            if (mrsp.valid && (mrsp.hit || mrsp.last)) begin
               flush        = 1'b1;
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_found_in = mrsp.hit;
               rsp_ifc_in   = mrsp.hit ? mrsp.idx : '0;
               rsp_type_in  = mrsp.hit ? mrsp.qtype : '0;
               rsp_qid_in   = mrsp.hit ? mrsp.qid : '0;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         issue_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         rd_vld_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issue_ff     <= issue_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_vld_ff    <= rd_en;
      end
      addr_ff      <= addr_in;
      rsp_found_ff <= rsp_found_in;
      rsp_ifc_ff   <= rsp_ifc_in;
      rsp_type_ff  <= rsp_type_in;
      rsp_qid_ff   <= rsp_qid_in;
      rd_last_ff   <= issue_ff == CNT_W'(NUM_INTERFACES - 1);
      rd_idx_ff    <= IFC_W'(issue_ff);
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_found_ff;
   assign rsp_tdata  = {{RSP_PAD{1'b0}}, rsp_qid_ff, rsp_type_ff, rsp_ifc_ff};

   // match results only come out while a scan is running
   a_match_in_lookup : assert property (@(posedge clock) disable iff (reset)
      mrsp.valid |-> state_ff == ST_LOOKUP)
      else $error("match result outside a lookup scan");

   // a response beat only appears at the end of a scan
   a_rsp_from_scan : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_LOOKUP))
      else $error("response raised without a finished scan");

   // the response slot stays empty for the whole scan
   a_slot_free : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LOOKUP |-> !rsp_valid_ff)
      else $error("response pending during scan");

   a_issue_range : assert property (@(posedge clock) disable iff (reset)
      issue_ff <= CNT_W'(NUM_INTERFACES))
      else $error("scan index ran past the table");

endmodule

`default_nettype wire
